>>> rtl/adg_pkg.sv
// Shared types, constants and helpers of the Adagrad element update engine.
package adg_pkg;

	localparam int IDX_W   = 12;
	localparam int DATA_W  = 32;
	localparam int ACC_W   = 48;
	localparam int ROOT_W  = 40;
	localparam int STD_W   = 41;
	localparam int QUO_W   = 34;

	localparam logic [63:0]      ONE_Q24    = 64'h0000_0000_0100_0000;
	localparam logic [ACC_W-1:0] ACC_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [QUO_W-1:0] STEP_LIMIT = 34'h2_0000_0000;

	localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] REG_RATE_DECAY    = 2'd1;
	localparam logic [1:0] REG_DECAY_WEIGHT  = 2'd2;
	localparam logic [1:0] REG_EPSILON       = 2'd3;

	typedef struct packed {
		logic clear;     // zero one accumulator entry
		logic load;      // capture an input transfer
		logic mult;      // decay and rate products, accumulator read
		logic grad;      // decayed gradient, rate denominator
		logic square;    // gradient square
		logic accum;     // accumulate, write back, start root and rate division
		logic prod;      // root plus epsilon, rate times gradient
		logic quot;      // start step division
		logic out_load;  // form the result
	} adg_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic root_busy;
		logic div_busy;
	} adg_status_t;

	// Clamp a signed 42-bit value to the signed 32-bit range; MSB flags a clamp.
	function automatic logic [32:0] clamp_s32(input logic [41:0] v);
		logic [32:0] r;
		if (!v[41] && (|v[40:31]))
			r = {1'b1, 32'h7FFF_FFFF};
		else if (v[41] && !(&v[40:31]))
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

>>> rtl/adg_div.sv
// Restoring divider, one quotient bit per cycle, 32 or 34 quotient bits.
module adg_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 wide,
	input  logic [63:0]          num,
	input  logic [63:0]          den,
	output logic                 busy,
	output logic [adg_pkg::QUO_W-1:0] quo
);
	import adg_pkg::*;

	logic [63:0]      rem_q;
	logic [97:0]      dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic             ge;

	assign ge   = {34'b0, rem_q} >= dsh_q;
	assign busy = cnt_q != 6'd0;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= wide ? 6'(QUO_W) : 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
			dsh_q <= wide ? {1'b0, den, 33'b0} : {3'b0, den, 31'b0};
		end else if (busy) begin
			if (ge)
				rem_q <= rem_q - dsh_q[63:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= {1'b0, dsh_q[97:1]};
		end
	end

endmodule

>>> rtl/adg_sqrt.sv
// Digit-by-digit square root of acc * 2^32, one root bit per cycle.
module adg_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [adg_pkg::ACC_W-1:0]  value,
	output logic                       busy,
	output logic [adg_pkg::ROOT_W-1:0] root
);
	import adg_pkg::*;

	logic [79:0]       x_q;
	logic [41:0]       rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [5:0]        cnt_q;
	logic [43:0]       r2;
	logic [43:0]       trial;
	logic              ge;

	assign r2    = {rem_q, x_q[79:78]};
	assign trial = {2'b0, root_q, 2'b01};
	assign ge    = r2 >= trial;
	assign busy  = cnt_q != 6'd0;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'(ROOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= {value, 32'b0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rem_q  <= ge ? 42'(r2 - trial) : r2[41:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			x_q    <= {x_q[77:0], 2'b00};
		end
	end

endmodule

>>> rtl/adg_datapath.sv
// Datapath: config registers, step count, accumulator memory and arithmetic.
module adg_datapath #(
	parameter int NUM_ELEMENTS = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  adg_pkg::adg_cmd_t           cmd,
	output adg_pkg::adg_status_t        status,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic [adg_pkg::IDX_W-1:0]   element_index,
	input  logic [adg_pkg::DATA_W-1:0]  gradient,
	input  logic [adg_pkg::DATA_W-1:0]  param_value,
	input  logic                        new_step,
	output logic [adg_pkg::IDX_W-1:0]   result_index,
	output logic [adg_pkg::DATA_W-1:0]  updated_param,
	output logic                        saturated
);
	import adg_pkg::*;

	localparam int ADDR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam int CNT_W  = $clog2(NUM_ELEMENTS + 1);

	logic [31:0] lr_q, decay_q, wd_q, eps_q, step_q;
	logic [CNT_W-1:0] clr_cnt_q;
	logic [ACC_W-1:0] mem [NUM_ELEMENTS];

	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       g_q, p_q, g2_q;
	logic              in_range_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ACC_W-1:0]  rd_q;
	logic [63:0]       wdm_s1, elp_s1, sq_s1, den_q, prod_q;
	logic              sat_q, lim_q, zero_q;
	logic [STD_W-1:0]  std_q;

	logic [20:0]       idx_ext;
	logic [31:0]       pmag, gmag, elapsed;
	logic [41:0]       gsum, rsum;
	logic [32:0]       gclamp, rclamp;
	logic [64:0]       den_sum;
	logic [ACC_W:0]    acc_sum;
	logic [ACC_W-1:0]  acc_rd, acc_new;
	logic              acc_hit;
	logic              div_start, div_wide, div_busy, root_busy;
	logic [63:0]       div_num, div_den;
	logic [QUO_W-1:0]  quo, qv;
	logic [ROOT_W-1:0] root;

	assign status.clear_done = clr_cnt_q == CNT_W'(NUM_ELEMENTS);
	assign status.root_busy  = root_busy;
	assign status.div_busy   = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= 32'd167772;
			decay_q <= 32'd0;
			wd_q    <= 32'd0;
			eps_q   <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEARNING_RATE: lr_q    <= cfg_data;
				REG_RATE_DECAY:    decay_q <= cfg_data;
				REG_DECAY_WEIGHT:  wd_q    <= cfg_data;
				REG_EPSILON:       eps_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.load && new_step && step_q != 32'hFFFF_FFFF)
				step_q <= step_q + 32'd1;
			if (cmd.clear)
				clr_cnt_q <= clr_cnt_q + CNT_W'(1);
		end
	end

	assign idx_ext = 21'(element_index);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q      <= element_index;
			g_q        <= gradient;
			p_q        <= param_value;
			in_range_q <= idx_ext < 21'(NUM_ELEMENTS);
			addr_q     <= idx_ext[ADDR_W-1:0];
		end
	end

	// single write port shared by the clearing pass and the write-back
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem[clr_cnt_q[ADDR_W-1:0]] <= '0;
		else if (cmd.accum && in_range_q)
			mem[addr_q] <= acc_new;
		if (cmd.mult)
			rd_q <= mem[addr_q];
	end

	assign pmag    = p_q[31] ? (~p_q + 32'd1) : p_q;
	assign gmag    = g2_q[31] ? (~g2_q + 32'd1) : g2_q;
	assign elapsed = (step_q == 32'd0) ? 32'd0 : step_q - 32'd1;

	assign gsum = p_q[31] ? ({{10{g_q[31]}}, g_q} - {2'b0, wdm_s1[63:24]})
	                      : ({{10{g_q[31]}}, g_q} + {2'b0, wdm_s1[63:24]});
	assign gclamp  = clamp_s32(gsum);
	assign den_sum = {1'b0, elp_s1} + {1'b0, ONE_Q24};

	assign acc_rd  = in_range_q ? rd_q : '0;
	assign acc_sum = {1'b0, acc_rd} + {1'b0, sq_s1[63:16]};
	assign acc_hit = acc_sum[ACC_W];
	assign acc_new = acc_hit ? ACC_MAX : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			wdm_s1 <= 64'(wd_q) * 64'(pmag);
			elp_s1 <= 64'(elapsed) * 64'(decay_q);
		end
		if (cmd.grad) begin
			g2_q  <= gclamp[31:0];
			den_q <= den_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : den_sum[63:0];
		end
		if (cmd.square)
			sq_s1 <= 64'(gmag) * 64'(gmag);
		if (cmd.accum)
			sat_q <= acc_hit;
		if (cmd.prod) begin
			std_q  <= {1'b0, root} + STD_W'(eps_q);
			prod_q <= 64'(quo[31:0]) * 64'(gmag);
		end
		if (cmd.quot) begin
			zero_q <= (std_q == '0) && (prod_q == 64'd0);
			lim_q  <= {11'b0, prod_q} >= {std_q, 34'b0};
		end
	end

	assign div_start = cmd.accum || cmd.quot;
	assign div_wide  = cmd.quot;
	assign div_num   = cmd.quot ? prod_q : {8'b0, lr_q, 24'b0};
	assign div_den   = cmd.quot ? 64'(std_q) : den_q;

	adg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.wide   (div_wide),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	adg_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accum),
		.value  (acc_new),
		.busy   (root_busy),
		.root   (root)
	);

	// zero divisor with a nonzero product also lands on the limit
	assign qv = zero_q ? '0 : ((lim_q || quo > STEP_LIMIT) ? STEP_LIMIT : quo);
	assign rsum = g2_q[31] ? ({{10{p_q[31]}}, p_q} + {8'b0, qv})
	                       : ({{10{p_q[31]}}, p_q} - {8'b0, qv});
	assign rclamp = clamp_s32(rsum);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_index  <= idx_q;
			updated_param <= rclamp[31:0];
			saturated     <= sat_q | rclamp[32];
		end
	end

endmodule

>>> rtl/adg_ctrl.sv
// Controller: sequences one element through the datapath, owns the handshakes.
module adg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  adg_pkg::adg_status_t status,
	output adg_pkg::adg_cmd_t    cmd
);
	import adg_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_MULT   = 4'd2;
	localparam logic [3:0] ST_GRAD   = 4'd3;
	localparam logic [3:0] ST_SQUARE = 4'd4;
	localparam logic [3:0] ST_ACCUM  = 4'd5;
	localparam logic [3:0] ST_ROOT   = 4'd6;
	localparam logic [3:0] ST_PROD   = 4'd7;
	localparam logic [3:0] ST_QUOT   = 4'd8;
	localparam logic [3:0] ST_DIVIDE = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = !status.clear_done;
				if (status.clear_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid)
					state_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_GRAD;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_ROOT;
			end
			ST_ROOT: begin
				if (!status.root_busy && !status.div_busy)
					state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (!status.div_busy)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free or drains now
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/adagrad_element_update.sv
// Top level of the Adagrad element update engine.
//
// Input stream (s_*): one parameter element per transfer, carrying its index,
// gradient and current value; s_tuser flags the first element of a new step.
// Output stream (m_*): one result per input, in order: index, updated value
// and a flag that the accumulator or the result clamped.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (learning rate, rate decay, weight decay, epsilon); write only when idle.
// One element at a time passes the mult, grad, square, accum, root, prod,
// quot, divide and out states; s_tready is high only when idle.
// The square root runs beside the rate division, followed by the step
// division through the same shared divider.
// Reset: a clearing pass writes zero to each accumulator entry, one per
// cycle; s_tready stays low until it ends.
// A stalled receiver: the finished result waits in the output register and
// the next element is still taken; its own result waits in the datapath.
module adagrad_element_update #(
	parameter int NUM_ELEMENTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // element_index, gradient, param_value, zero pad
	input  logic        s_tuser,  // new_step
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_index, updated_param, zero pad
	output logic        m_tuser,  // saturated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import adg_pkg::*;

	adg_cmd_t          cmd;
	adg_status_t       status;
	logic [IDX_W-1:0]  result_index;
	logic [DATA_W-1:0] updated_param;

	adg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	adg_datapath #(
		.NUM_ELEMENTS (NUM_ELEMENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_index (s_tdata[11:0]),
		.gradient      (s_tdata[43:12]),
		.param_value   (s_tdata[75:44]),
		.new_step      (s_tuser),
		.result_index  (result_index),
		.updated_param (updated_param),
		.saturated     (m_tuser)
	);

	assign m_tdata = {4'b0, updated_param, result_index};

endmodule

>>> rtl/adg_checker.sv
// Port-level checks of the Adagrad element update engine, bound to the top.
module adg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	logic [1:0] cnt_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// elements taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (in_xfer && !out_xfer)
			cnt_q <= cnt_q + 2'd1;
		else if (out_xfer && !in_xfer)
			cnt_q <= cnt_q - 2'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input taken while an element is in work");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 2'd0)
		else $error("result without a pending element");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("more than two elements in flight");

endmodule

bind adagrad_element_update adg_checker u_adg_checker (.*);
